@@ src/cds_pkg.sv @@
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types, codes and calendar functions for the date stepper.
// ----------------------------------------------------------------------------
package cds_pkg;

	localparam int DAY_W     = 5;
	localparam int MONTH_W   = 4;
	localparam int YEAR_W    = 14;
	localparam int ORDINAL_W = 9;
	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_NEXT   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PREV   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_REPORT = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_LIMIT  = 2'd2;

	localparam logic [YEAR_W-1:0]    YEAR_MIN       = 14'd1;
	localparam logic [YEAR_W-1:0]    YEAR_MAX       = 14'd9999;
	localparam logic [YEAR_W-1:0]    LEAP_FLOOR     = 14'd1000;
	localparam logic [ORDINAL_W-1:0] DAYS_YEAR      = 9'd365;
	localparam logic [ORDINAL_W-1:0] DAYS_LEAP_YEAR = 9'd366;
	localparam logic [MONTH_W-1:0]   MONTH_JAN      = 4'd1;
	localparam logic [MONTH_W-1:0]   MONTH_DEC      = 4'd12;
	localparam logic [DAY_W-1:0]     DAY_FIRST      = 5'd1;
	localparam logic [DAY_W-1:0]     DAY_LAST_DEC   = 5'd31;

	// reciprocal of 25 scaled by 2^17, exact quotient for any 14-bit year
	localparam int RECIP25_SHIFT = 17;
	localparam int RECIP25_W     = 13;
	localparam int PROD25_W      = YEAR_W + RECIP25_W;
	localparam logic [RECIP25_W-1:0] RECIP25 = 13'd5243;

	typedef struct packed {
		logic [DAY_W-1:0]     day;
		logic [MONTH_W-1:0]   month;
		logic [YEAR_W-1:0]    year;
		logic [ORDINAL_W-1:0] ordinal;
		logic                 leap;
	} date_t;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [DAY_W-1:0]   load_day;
		logic [MONTH_W-1:0] load_month;
		logic [YEAR_W-1:0]  load_year;
		logic               load_leap;
	} cmd_item_t;

	typedef struct packed {
		date_t                date;
		logic [STATUS_W-1:0]  status;
	} res_item_t;

	// Gregorian rule, but no year below 1000 is leap
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [PROD25_W-1:0] prod;
		logic [YEAR_W-1:0]   quot;
		logic [YEAR_W-1:0]   back;
		logic                div25;
		prod  = PROD25_W'(y) * PROD25_W'(RECIP25);
		quot  = YEAR_W'(prod >> RECIP25_SHIFT);
		back  = quot * YEAR_W'(25);
		div25 = (back == y);
		return (y >= LEAP_FLOOR) && (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
	endfunction

	// length of a month, zero for a month code that means nothing
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
			4'd2:                                      len = leap ? 5'd29 : 5'd28;
			default:                                   len = 5'd0;
		endcase
		return len;
	endfunction

	// days in the year before the first of a month
	function automatic logic [ORDINAL_W-1:0] days_before(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [ORDINAL_W-1:0] base;
		logic [ORDINAL_W-1:0] adj;
		case (m)
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		adj = (leap && (m >= 4'd3) && (m <= MONTH_DEC)) ? 9'd1 : 9'd0;
		return base + adj;
	endfunction

	function automatic logic [ORDINAL_W-1:0] year_len(input logic leap);
		return leap ? DAYS_LEAP_YEAR : DAYS_YEAR;
	endfunction

endpackage

@@ src/cds_cmd_if.sv @@
// ----------------------------------------------------------------------------
// cds_cmd_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface cds_cmd_if
	import cds_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [DAY_W-1:0]   load_day;
	logic [MONTH_W-1:0] load_month;
	logic [YEAR_W-1:0]  load_year;

	modport source (output valid, command, load_day, load_month, load_year,
		input ready);
	modport sink (input valid, command, load_day, load_month, load_year,
		output ready);
endinterface

@@ src/cds_res_if.sv @@
// ----------------------------------------------------------------------------
// cds_res_if
// Result channel: valid/ready handshake with the date report payload.
// ----------------------------------------------------------------------------
interface cds_res_if
	import cds_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [DAY_W-1:0]     day;
	logic [MONTH_W-1:0]   month;
	logic [YEAR_W-1:0]    year;
	logic [ORDINAL_W-1:0] day_of_year;
	logic                 leap;
	logic [STATUS_W-1:0]  status;

	modport source (output valid, day, month, year, day_of_year, leap, status,
		input ready);
	modport sink (input valid, day, month, year, day_of_year, leap, status,
		output ready);
endinterface

@@ src/calendar_date_stepper.sv @@
// ----------------------------------------------------------------------------
// calendar_date_stepper
// Calendar date counter stepping one day per next or previous command, with validated loads.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command per transaction: load a date, next day, previous
//   day or report only. res returns exactly one report per command: the date
//   after the command, its day of year, the leap flag and a status (ok, load
//   rejected, year range limit held).
//   The input register captures the command at its transaction edge and the
//   step logic then fills the result register from it when res is not stalled,
//   so the report is presented from the result register. Throughput is one
//   command per cycle while res is not stalled; the date register updates in
//   the same cycle the step logic fires, so back-to-back commands chain.
//   Reset sets the date to 1 January 2000 (leap, day of year 1) and empties
//   both registers. When the receiver stalls, the result register holds its
//   report and the input register takes one more command, then cmd.ready
//   drops until res is taken.
// ----------------------------------------------------------------------------
module calendar_date_stepper
	import cds_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	cds_cmd_if.sink   cmd,
	cds_res_if.source res
);

	logic      valid_s1;
	logic      take;
	cmd_item_t item_s1;
	date_t     date_q;
	res_item_t result;

	// step when an item waits and the result register is free
	assign take = valid_s1 && (!res.valid || res.ready);

	cds_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	cds_date_core u_date_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.item_s1 (item_s1),
		.date_q  (date_q),
		.result  (result)
	);

	cds_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.result (result),
		.res    (res)
	);

	// leap flag always agrees with the stored year
	a_leap_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		date_q.leap == is_leap(date_q.year))
		else $error("leap flag out of step with year");

	// day of year always agrees with month and day
	a_ordinal_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		date_q.ordinal == days_before(date_q.month, date_q.leap) + ORDINAL_W'(date_q.day))
		else $error("day of year out of step with month and day");

	// a rejected load or a held limit leaves the date untouched
	a_hold_on_status: assert property (@(posedge clk) disable iff (!arst_n)
		(take && result.status != STATUS_OK) |=> $stable(date_q))
		else $error("date changed on rejected or held transaction");

	// back-pressure only when both registers are full and res is stalled
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> (valid_s1 && res.valid && !res.ready))
		else $error("command channel stalled without cause");

endmodule

@@ src/cds_in_stage.sv @@
// ----------------------------------------------------------------------------
// cds_in_stage
// Input register: captures a command transaction and the leap flag of its
// load year, and holds it until the step logic takes it.
// ----------------------------------------------------------------------------
module cds_in_stage
	import cds_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	cds_cmd_if.sink   cmd,
	input  logic      take,
	output logic      valid_s1,
	output cmd_item_t item_s1
);

	// accept when the register is empty or drains this cycle
	assign cmd.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// capture payload; work out the load year's leap flag on the way in
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.command    <= cmd.command;
			item_s1.load_day   <= cmd.load_day;
			item_s1.load_month <= cmd.load_month;
			item_s1.load_year  <= cmd.load_year;
			item_s1.load_leap  <= is_leap(cmd.load_year);
		end
	end

endmodule

@@ src/cds_date_core.sv @@
// ----------------------------------------------------------------------------
// cds_date_core
// Date state and the one-day step: load with validation, next day, previous
// day and report. Produces the result for the item in the input register.
// ----------------------------------------------------------------------------
module cds_date_core
	import cds_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      take,
	input  cmd_item_t item_s1,
	output date_t     date_q,
	output res_item_t result
);

	date_t               nxt;
	logic [STATUS_W-1:0] status;
	logic [DAY_W-1:0]    cur_len;
	logic [DAY_W-1:0]    prev_len;
	logic [MONTH_W-1:0]  prev_month;
	logic                load_ok;
	logic                leap_up;
	logic                leap_down;

	assign cur_len    = month_len(date_q.month, date_q.leap);
	assign prev_month = date_q.month - MONTH_W'(1);
	assign prev_len   = month_len(prev_month, date_q.leap);
	assign leap_up    = is_leap(date_q.year + YEAR_W'(1));
	assign leap_down  = is_leap(date_q.year - YEAR_W'(1));

	assign load_ok = (item_s1.load_month >= MONTH_JAN) && (item_s1.load_month <= MONTH_DEC)
		&& (item_s1.load_year >= YEAR_MIN) && (item_s1.load_year <= YEAR_MAX)
		&& (item_s1.load_day >= DAY_FIRST)
		&& (item_s1.load_day <= month_len(item_s1.load_month, item_s1.load_leap));

	// work out the next date and the status of this transaction
	always_comb begin
		nxt    = date_q;
		status = STATUS_OK;
		unique case (item_s1.command)
			CMD_LOAD: begin
				if (load_ok) begin
					nxt.day     = item_s1.load_day;
					nxt.month   = item_s1.load_month;
					nxt.year    = item_s1.load_year;
					nxt.leap    = item_s1.load_leap;
					nxt.ordinal = days_before(item_s1.load_month, item_s1.load_leap)
						+ ORDINAL_W'(item_s1.load_day);
				end else begin
					status = STATUS_REJECT;
				end
			end
			CMD_NEXT: begin
				if (date_q.ordinal < year_len(date_q.leap)) begin
					nxt.ordinal = date_q.ordinal + ORDINAL_W'(1);
					if (date_q.day == cur_len) begin
						nxt.day   = DAY_FIRST;
						nxt.month = date_q.month + MONTH_W'(1);
					end else begin
						nxt.day = date_q.day + DAY_W'(1);
					end
				end else if (date_q.year >= YEAR_MAX) begin
					status = STATUS_LIMIT;
				end else begin
					nxt.year    = date_q.year + YEAR_W'(1);
					nxt.leap    = leap_up;
					nxt.ordinal = ORDINAL_W'(1);
					nxt.day     = DAY_FIRST;
					nxt.month   = MONTH_JAN;
				end
			end
			CMD_PREV: begin
				if (date_q.ordinal > ORDINAL_W'(1)) begin
					nxt.ordinal = date_q.ordinal - ORDINAL_W'(1);
					if (date_q.day == DAY_FIRST) begin
						nxt.day   = prev_len;
						nxt.month = prev_month;
					end else begin
						nxt.day = date_q.day - DAY_W'(1);
					end
				end else if (date_q.year <= YEAR_MIN) begin
					status = STATUS_LIMIT;
				end else begin
					nxt.year    = date_q.year - YEAR_W'(1);
					nxt.leap    = leap_down;
					nxt.ordinal = year_len(leap_down);
					nxt.day     = DAY_LAST_DEC;
					nxt.month   = MONTH_DEC;
				end
			end
			CMD_REPORT: begin
				status = STATUS_OK;
			end
		endcase
	end

	assign result.date   = nxt;
	assign result.status = status;

	// hold the date; reset to the first of January 2000
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			date_q.day     <= DAY_FIRST;
			date_q.month   <= MONTH_JAN;
			date_q.year    <= YEAR_W'(2000);
			date_q.ordinal <= ORDINAL_W'(1);
			date_q.leap    <= 1'b1;
		end else if (take) begin
			date_q <= nxt;
		end
	end

endmodule

@@ src/cds_out_reg.sv @@
// ----------------------------------------------------------------------------
// cds_out_reg
// Result register: holds a finished report until the receiver takes it.
// ----------------------------------------------------------------------------
module cds_out_reg
	import cds_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      take,
	input  res_item_t result,
	cds_res_if.source res
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (take) begin
			res.valid <= 1'b1;
		end else if (res.ready) begin
			res.valid <= 1'b0;
		end
	end

	// load payload when a new result is produced
	always_ff @(posedge clk) begin
		if (take) begin
			res.day         <= result.date.day;
			res.month       <= result.date.month;
			res.year        <= result.date.year;
			res.day_of_year <= result.date.ordinal;
			res.leap        <= result.date.leap;
			res.status      <= result.status;
		end
	end

endmodule
